// ----- hdl/median_filter_3x3_border_unit_macros.svh -----
// assertion macros for the median filter block
`ifndef MEDIAN_FILTER_3X3_BORDER_UNIT_MACROS_SVH
`define MEDIAN_FILTER_3X3_BORDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define MF3B_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// condition implies consequence in the next cycle
`define MF3B_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define MF3B_ASSERT_SAME(label, clk, rst_n, cond, cons, msg)
`define MF3B_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg)
`endif

`endif

// ----- hdl/mf3b_pkg.sv -----
// shared types and constants of the 3x3 border median filter
package mf3b_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_BITS  = 11;
    localparam int DIM_BITS   = 12;
    localparam int POS_BITS   = 11;
    localparam int WIN_SIZE   = 9;

    localparam logic [DIM_BITS-1:0] DIM_MIN        = 12'd2;
    localparam logic [DIM_BITS-1:0] DIM_MAX        = 12'd2048;
    localparam logic [DIM_BITS-1:0] ROW_SAT        = 12'hFFF;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET    = 12'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET   = 12'd480;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // word kinds on the input channel
    localparam logic KIND_PIXEL = 1'b0;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [3:0]            rank_t;

    // control carried along with a word through the pipeline
    typedef struct packed {
        logic                real_px;
        logic                emit;
        pixel_t              value;
        logic [ADDR_BITS-1:0] addr;
        logic [2:0]          row_mask;
        logic [2:0]          col_mask;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                last;
    } ctrl_t;

    // result position fields
    typedef struct packed {
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                last;
    } pos_t;

endpackage

// ----- hdl/median_filter_3x3_border_unit.sv -----
// top level of the streaming 3x3 border median filter
// Usage:
// Pixels of one channel enter in raster order on the in channel (in_valid,
// in_stall, kind, pixel_value); kind marks a pixel word or a flush word.
// Each word is accepted when in_valid is high and in_stall is low.
// The result for a pixel leaves on the out channel (out_valid, out_stall)
// with its row, column and a last_of_image mark, once the pixel one row
// and one column further has arrived; after the image, image_width + 1
// flush words release the outstanding results, one each.
// A word enters every cycle while in_stall is low; a released result moves through
// the stage 1, stage 2, stage 3 and output registers. Stages: line buffer read with window
// shift and pairwise compare, rank selection, mean of the two middle values.
// The two line buffers are single-port-read rams read at the input column
// and written back as the word leaves the first stage.
// A stall on the out channel fills the stages behind the output register
// and then raises in_stall; no word is lost or repeated.
// Reset clears the window, the positions and the pipeline, and sets the
// size to 640 by 480; line buffer contents are not cleared.
// image_width and image_height are written through cfg_write, cfg_index
// and cfg_data while the block is idle.
`include "median_filter_3x3_border_unit_macros.svh"

module median_filter_3x3_border_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [mf3b_pkg::DIM_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [mf3b_pkg::PIXEL_BITS-1:0]     pixel_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mf3b_pkg::PIXEL_BITS-1:0]     median_value,
    output logic [mf3b_pkg::POS_BITS-1:0]       out_row,
    output logic [mf3b_pkg::POS_BITS-1:0]       out_col,
    output logic                                last_of_image
);

    // configuration registers
    logic [mf3b_pkg::DIM_BITS-1:0] image_width_reg;
    logic [mf3b_pkg::DIM_BITS-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= mf3b_pkg::WIDTH_RESET;
            image_height_reg <= mf3b_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mf3b_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                mf3b_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:                    image_width_reg  <= image_width_reg;
            endcase
        end
    end

    // clamped image size
    logic [mf3b_pkg::DIM_BITS-1:0] eff_w;
    logic [mf3b_pkg::DIM_BITS-1:0] eff_h;

    always_comb
    begin
        if (image_width_reg < mf3b_pkg::DIM_MIN)
            eff_w = mf3b_pkg::DIM_MIN;
        else if (image_width_reg > mf3b_pkg::DIM_MAX)
            eff_w = mf3b_pkg::DIM_MAX;
        else
            eff_w = image_width_reg;
        if (image_height_reg < mf3b_pkg::DIM_MIN)
            eff_h = mf3b_pkg::DIM_MIN;
        else if (image_height_reg > mf3b_pkg::DIM_MAX)
            eff_h = mf3b_pkg::DIM_MAX;
        else
            eff_h = image_height_reg;
    end

    // pipeline handshake
    logic                     s1_valid_reg;
    mf3b_pkg::ctrl_t          s1_ctrl_reg;
    logic                     s2_valid_reg;
    logic                     s3_valid_reg;
    logic                     out_valid_reg;
    logic                     out_free;
    logic                     s3_free;
    logic                     s2_free;
    logic                     s1_leave;
    logic                     in_acc;
    logic                     ignore;
    logic                     go;

    assign out_free = !out_valid_reg || !out_stall;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_leave = s1_valid_reg && (!s1_ctrl_reg.emit || s2_free);
    assign in_stall = s1_valid_reg && !s1_leave;
    assign in_acc   = in_valid && !in_stall;
    assign go       = in_acc && !ignore;

    // input and result positions
    logic [mf3b_pkg::DIM_BITS-1:0] in_row_reg;
    logic [mf3b_pkg::POS_BITS-1:0] in_col_reg;
    logic [mf3b_pkg::DIM_BITS-1:0] emit_row_reg;
    logic [mf3b_pkg::POS_BITS-1:0] emit_col_reg;
    logic                          real_px;
    logic                          emit_ok;
    logic                          base_one;
    logic [mf3b_pkg::DIM_BITS-1:0] in_col_inc;
    logic [mf3b_pkg::DIM_BITS-1:0] emit_col_inc;
    mf3b_pkg::ctrl_t               s0_ctrl;

    always_comb
    begin
        real_px      = (kind == mf3b_pkg::KIND_PIXEL);
        in_col_inc   = {1'b0, in_col_reg} + 12'd1;
        emit_col_inc = {1'b0, emit_col_reg} + 12'd1;
        if (real_px)
            ignore = (in_row_reg >= eff_h);
        else
            ignore = (in_row_reg < eff_h) || (emit_row_reg >= eff_h);
        emit_ok  = ((in_row_reg >= 12'd2) || ((in_row_reg == 12'd1) && (in_col_reg != '0)))
                   && (emit_row_reg < eff_h);
        base_one = (in_col_reg == '0);

        s0_ctrl.real_px     = real_px;
        s0_ctrl.emit        = emit_ok;
        s0_ctrl.value       = real_px ? pixel_value : '0;
        s0_ctrl.addr        = in_col_reg;
        s0_ctrl.row_mask[0] = (emit_row_reg >= 12'd1);
        s0_ctrl.row_mask[1] = 1'b1;
        s0_ctrl.row_mask[2] = ((emit_row_reg + 12'd1) < eff_h);
        s0_ctrl.col_mask[0] = (emit_col_reg != '0);
        s0_ctrl.col_mask[1] = 1'b1;
        s0_ctrl.col_mask[2] = (emit_col_inc < eff_w) && !base_one;
        s0_ctrl.row         = emit_row_reg[mf3b_pkg::POS_BITS-1:0];
        s0_ctrl.col         = emit_col_reg;
        s0_ctrl.last        = (emit_row_reg == (eff_h - 12'd1))
                              && ({1'b0, emit_col_reg} == (eff_w - 12'd1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
        end
        else if (go)
        begin
            if (in_col_inc >= eff_w)
            begin
                in_col_reg <= '0;
                if (in_row_reg != mf3b_pkg::ROW_SAT)
                    in_row_reg <= in_row_reg + 12'd1;
            end
            else
            begin
                in_col_reg <= in_col_inc[mf3b_pkg::POS_BITS-1:0];
            end
            if (emit_ok)
            begin
                if (emit_col_inc >= eff_w)
                begin
                    emit_col_reg <= '0;
                    emit_row_reg <= emit_row_reg + 12'd1;
                end
                else
                begin
                    emit_col_reg <= emit_col_inc[mf3b_pkg::POS_BITS-1:0];
                end
            end
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (go)
            s1_valid_reg <= 1'b1;
        else if (s1_leave)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go)
            s1_ctrl_reg <= s0_ctrl;
    end

    // line buffers: read at the input column, written back as the word leaves stage 1
    mf3b_pkg::pixel_t upper_rd;
    mf3b_pkg::pixel_t middle_rd;
    logic             lb_wr;

    assign lb_wr = s1_leave && s1_ctrl_reg.real_px;

    mf3b_ram #(
        .WIDTH (mf3b_pkg::PIXEL_BITS),
        .DEPTH (mf3b_pkg::MAX_WIDTH)
    ) u_upper_line (
        .clk     (clk),
        .wr_en   (lb_wr),
        .wr_addr (s1_ctrl_reg.addr),
        .wr_data (middle_rd),
        .rd_en   (go),
        .rd_addr (in_col_reg),
        .rd_data (upper_rd)
    );

    mf3b_ram #(
        .WIDTH (mf3b_pkg::PIXEL_BITS),
        .DEPTH (mf3b_pkg::MAX_WIDTH)
    ) u_middle_line (
        .clk     (clk),
        .wr_en   (lb_wr),
        .wr_addr (s1_ctrl_reg.addr),
        .wr_data (s1_ctrl_reg.value),
        .rd_en   (go),
        .rd_addr (in_col_reg),
        .rd_data (middle_rd)
    );

    // window shift
    mf3b_pkg::pixel_t window_reg  [3][3];
    mf3b_pkg::pixel_t window_next [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            window_next[r][0] = window_reg[r][1];
            window_next[r][1] = window_reg[r][2];
        end
        window_next[0][2] = upper_rd;
        window_next[1][2] = middle_rd;
        window_next[2][2] = s1_ctrl_reg.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    window_reg[r][c] <= '0;
        end
        else if (s1_leave)
        begin
            window_reg <= window_next;
        end
    end

    // pairwise ordering of the window values
    mf3b_pkg::pixel_t             s1_vals    [mf3b_pkg::WIN_SIZE];
    logic [mf3b_pkg::WIN_SIZE-1:0] s1_present;
    logic [mf3b_pkg::WIN_SIZE-1:0] s1_prec   [mf3b_pkg::WIN_SIZE];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                s1_vals[r*3+c]    = window_next[r][c];
                s1_present[r*3+c] = s1_ctrl_reg.row_mask[r] && s1_ctrl_reg.col_mask[c];
            end
        // s1_prec[i][j]: value j sorts ahead of value i
        for (int i = 0; i < mf3b_pkg::WIN_SIZE; i++)
            for (int j = 0; j < mf3b_pkg::WIN_SIZE; j++)
                s1_prec[i][j] = (j != i) && ((s1_vals[j] < s1_vals[i])
                                || ((s1_vals[j] == s1_vals[i]) && (j < i)));
    end

    mf3b_pkg::pixel_t              s2_vals_reg    [mf3b_pkg::WIN_SIZE];
    logic [mf3b_pkg::WIN_SIZE-1:0] s2_present_reg;
    logic [mf3b_pkg::WIN_SIZE-1:0] s2_prec_reg    [mf3b_pkg::WIN_SIZE];
    mf3b_pkg::pos_t                s2_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= (s1_leave && s1_ctrl_reg.emit) || (s2_valid_reg && !s3_free);
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave && s1_ctrl_reg.emit)
        begin
            s2_vals_reg    <= s1_vals;
            s2_present_reg <= s1_present;
            s2_prec_reg    <= s1_prec;
            s2_pos_reg     <= '{row: s1_ctrl_reg.row, col: s1_ctrl_reg.col,
                                last: s1_ctrl_reg.last};
        end
    end

    // ranks and selection of the two middle values
    mf3b_pkg::rank_t  s2_count;
    mf3b_pkg::rank_t  lo_rank;
    mf3b_pkg::rank_t  hi_rank;
    logic             rank_known;
    mf3b_pkg::rank_t  rank [mf3b_pkg::WIN_SIZE];
    mf3b_pkg::pixel_t s2_lo;
    mf3b_pkg::pixel_t s2_hi;

    always_comb
    begin
        s2_count = '0;
        for (int i = 0; i < mf3b_pkg::WIN_SIZE; i++)
            s2_count = s2_count + {3'b000, s2_present_reg[i]};
        rank_known = 1'b1;
        case (s2_count)
            4'd9:
            begin
                lo_rank = 4'd4;
                hi_rank = 4'd4;
            end
            4'd6:
            begin
                lo_rank = 4'd2;
                hi_rank = 4'd3;
            end
            4'd4:
            begin
                lo_rank = 4'd1;
                hi_rank = 4'd2;
            end
            default:
            begin
                lo_rank    = '0;
                hi_rank    = '0;
                rank_known = 1'b0;
            end
        endcase
        for (int i = 0; i < mf3b_pkg::WIN_SIZE; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < mf3b_pkg::WIN_SIZE; j++)
                rank[i] = rank[i] + {3'b000, s2_prec_reg[i][j] && s2_present_reg[j]};
        end
        s2_lo = '0;
        s2_hi = '0;
        for (int i = 0; i < mf3b_pkg::WIN_SIZE; i++)
        begin
            if (rank_known && s2_present_reg[i] && (rank[i] == lo_rank))
                s2_lo = s2_lo | s2_vals_reg[i];
            if (rank_known && s2_present_reg[i] && (rank[i] == hi_rank))
                s2_hi = s2_hi | s2_vals_reg[i];
        end
    end

    mf3b_pkg::pixel_t s3_lo_reg;
    mf3b_pkg::pixel_t s3_hi_reg;
    mf3b_pkg::pos_t   s3_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= (s2_valid_reg && s3_free) || (s3_valid_reg && !out_free);
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_free)
        begin
            s3_lo_reg  <= s2_lo;
            s3_hi_reg  <= s2_hi;
            s3_pos_reg <= s2_pos_reg;
        end
    end

    // mean of the middle pair into the output register
    logic [mf3b_pkg::PIXEL_BITS:0] mid_sum;
    mf3b_pkg::pixel_t              median_reg;
    mf3b_pkg::pos_t                out_pos_reg;

    assign mid_sum = {1'b0, s3_lo_reg} + {1'b0, s3_hi_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= (s3_valid_reg && out_free) || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_free)
        begin
            median_reg  <= mid_sum[mf3b_pkg::PIXEL_BITS:1];
            out_pos_reg <= s3_pos_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign median_value  = median_reg;
    assign out_row       = out_pos_reg.row;
    assign out_col       = out_pos_reg.col;
    assign last_of_image = out_pos_reg.last;

    // checks
    `MF3B_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall, s1_valid_reg, "input held with stage 1 empty")
    `MF3B_ASSERT_NEXT(a_word_enters_stage1, clk, rst_n, go, s1_valid_reg, "accepted word lost before stage 1")
    `MF3B_ASSERT_SAME(a_middle_pair_ordered, clk, rst_n, s3_valid_reg, s3_lo_reg <= s3_hi_reg, "middle pair out of order")

endmodule

// ----- hdl/mf3b_ram.sv -----
// generic single write port, single read port ram with registered read
module mf3b_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, output held while not read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- tb/tb_median_filter_3x3_border_unit.sv -----
// self-checking testbench of the streaming 3x3 border median filter
module tb_median_filter_3x3_border_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_FLUSH     = ~mf3b_pkg::KIND_PIXEL;
    localparam int   IDLE_WAIT      = 20;
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   LONG_HOLD      = 300;
    localparam logic [mf3b_pkg::DIM_BITS-1:0] IMG_WIDTH  = 12'd20;
    localparam logic [mf3b_pkg::DIM_BITS-1:0] IMG_HEIGHT = 12'd27;
    localparam int   FIRST_ROWS     = 10;

    typedef struct {
        logic [mf3b_pkg::PIXEL_BITS-1:0] median;
        logic [mf3b_pkg::POS_BITS-1:0]   row;
        logic [mf3b_pkg::POS_BITS-1:0]   col;
        logic                            last;
    } median_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic                            cfg_index = mf3b_pkg::REG_IMAGE_WIDTH;
    logic [mf3b_pkg::DIM_BITS-1:0]   cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            kind = mf3b_pkg::KIND_PIXEL;
    logic [mf3b_pkg::PIXEL_BITS-1:0] pixel_value = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [mf3b_pkg::PIXEL_BITS-1:0] median_value;
    logic [mf3b_pkg::POS_BITS-1:0]   out_row;
    logic [mf3b_pkg::POS_BITS-1:0]   out_col;
    logic                            last_of_image;

    median_filter_3x3_border_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .pixel_value   (pixel_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .median_value  (median_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_image (last_of_image)
    );

    always #2 clk = ~clk;

    // predicted filter state
    logic [mf3b_pkg::DIM_BITS-1:0]   width_reg = mf3b_pkg::WIDTH_RESET;
    logic [mf3b_pkg::DIM_BITS-1:0]   height_reg = mf3b_pkg::HEIGHT_RESET;
    logic [mf3b_pkg::PIXEL_BITS-1:0] upper_row [mf3b_pkg::MAX_WIDTH];
    logic [mf3b_pkg::PIXEL_BITS-1:0] middle_row [mf3b_pkg::MAX_WIDTH];
    logic [mf3b_pkg::PIXEL_BITS-1:0] window [3][3];
    int unsigned           next_row = 0, next_col = 0, res_row = 0, res_col = 0;
    median_word_t          expected_medians [$];

    int mismatches = 0;
    int burst_left = 0;
    int idle_count = 0;
    bit hold_request = 0;

    initial
    begin
        for (int i = 0; i < mf3b_pkg::MAX_WIDTH; i++)
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                window[r][c] = '0;
    end

    function automatic int unsigned clamp_dim(logic [mf3b_pkg::DIM_BITS-1:0] v);
        if (v < mf3b_pkg::DIM_MIN)
            return mf3b_pkg::DIM_MIN;
        if (v > mf3b_pkg::DIM_MAX)
            return mf3b_pkg::DIM_MAX;
        return v;
    endfunction

    // median of the clipped neighbourhood, mean of the middle pair on the border
    function automatic mf3b_pkg::pixel_t border_median(int unsigned w, int unsigned h,
                                                       int base);
        int  vals [9];
        int  n = 0;
        int  t, j;
        bit  top, bottom, left, right;
        top    = res_row >= 1;
        bottom = res_row + 1 < h;
        left   = res_col >= 1;
        right  = (res_col + 1 < w) && base == 0;
        for (int r = 0; r < 3; r++)
        begin
            if ((r == 0 && !top) || (r == 2 && !bottom))
                continue;
            for (int c = 0; c < 3; c++)
            begin
                if ((c == 0 && !left) || (c == 2 && !right) || c + base > 2)
                    continue;
                vals[n] = window[r][c + base];
                n++;
            end
        end
        for (int i = 1; i < n; i++)
        begin
            t = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > t)
            begin
                vals[j] = vals[j - 1];
                j--;
            end
            vals[j] = t;
        end
        if (n == 9)
            return mf3b_pkg::pixel_t'(vals[4]);
        if (n == 6)
            return mf3b_pkg::pixel_t'((vals[2] + vals[3]) >> 1);
        if (n == 4)
            return mf3b_pkg::pixel_t'((vals[1] + vals[2]) >> 1);
        return '0;
    endfunction

    function automatic void queue_median(int unsigned w, int unsigned h, int base);
        median_word_t m;
        m.median = border_median(w, h, base);
        m.row    = res_row[mf3b_pkg::POS_BITS-1:0];
        m.col    = res_col[mf3b_pkg::POS_BITS-1:0];
        m.last   = (res_row == h - 1) && (res_col == w - 1);
        expected_medians.push_back(m);
        if (res_col + 1 >= w)
        begin
            res_col = 0;
            res_row++;
        end
        else
            res_col++;
    endfunction

    function automatic void shift_window(int unsigned c, logic [mf3b_pkg::PIXEL_BITS-1:0] v,
                                         bit real_px);
        logic [mf3b_pkg::PIXEL_BITS-1:0] u, m;
        u = upper_row[c];
        m = middle_row[c];
        if (real_px)
        begin
            upper_row[c] = m;
            middle_row[c] = v;
        end
        for (int r = 0; r < 3; r++)
        begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
        end
        window[0][2] = u;
        window[1][2] = m;
        window[2][2] = v;
    endfunction

    // advance the predicted filter by one accepted word
    function automatic void predict_word(logic k, logic [mf3b_pkg::PIXEL_BITS-1:0] v);
        int unsigned w, h;
        bit          real_px, emit_ok;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        real_px = (k == mf3b_pkg::KIND_PIXEL);
        if (real_px && next_row >= h)
            return;
        if (!real_px && (next_row < h || res_row >= h))
            return;
        if (!real_px)
            v = '0;
        emit_ok = (next_row >= 2 || (next_row == 1 && next_col >= 1)) && res_row < h;
        if (next_col == 0)
        begin
            if (emit_ok)
                queue_median(w, h, 1);
            shift_window(next_col, v, real_px);
        end
        else
        begin
            shift_window(next_col, v, real_px);
            if (emit_ok)
                queue_median(w, h, 0);
        end
        if (next_col + 1 >= w)
        begin
            next_col = 0;
            if (next_row < mf3b_pkg::ROW_SAT)
                next_row++;
        end
        else
            next_col++;
    endfunction

    // send one word, in bursts with random gaps
    task automatic send_word(input logic k, input logic [mf3b_pkg::PIXEL_BITS-1:0] v);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        pixel_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        predict_word(k, v);
        burst_left--;
    endtask

    // stop sending and wait until every predicted word has arrived
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [mf3b_pkg::DIM_BITS-1:0] val);
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == mf3b_pkg::REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    function automatic mf3b_pkg::pixel_t random_pixel(int style);
        case (style)
            0: return mf3b_pkg::pixel_t'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return mf3b_pkg::pixel_t'($urandom_range(120, 136));
            default: return mf3b_pkg::pixel_t'($urandom);
        endcase
    endfunction

    task automatic send_rows(input int rows);
        int style;
        for (int r = 0; r < rows; r++)
        begin
            style = $urandom_range(0, 5);
            for (int c = 0; c < IMG_WIDTH; c++)
            begin
                // ignored flush noise inside the image
                if ($urandom_range(0, 40) == 0)
                    send_word(KIND_FLUSH, mf3b_pkg::pixel_t'($urandom));
                send_word(mf3b_pkg::KIND_PIXEL, random_pixel(style));
            end
        end
    endtask

    // register writes on an idle block, clamped values among them
    task automatic test_register_writes;
        write_reg(mf3b_pkg::REG_IMAGE_WIDTH, 12'd0);
        write_reg(mf3b_pkg::REG_IMAGE_HEIGHT, 12'd1);
        write_reg(mf3b_pkg::REG_IMAGE_WIDTH, 12'hFFF);
        write_reg(mf3b_pkg::REG_IMAGE_WIDTH, mf3b_pkg::DIM_MAX);
        write_reg(mf3b_pkg::REG_IMAGE_WIDTH, IMG_WIDTH);
        write_reg(mf3b_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
    endtask

    // flush words before the image is complete give nothing
    task automatic test_early_flush;
        repeat (3) send_word(KIND_FLUSH, mf3b_pkg::pixel_t'($urandom));
    endtask

    // top row with full-scale values and ties
    task automatic test_extreme_pixels;
        for (int c = 0; c < IMG_WIDTH; c++)
            send_word(mf3b_pkg::KIND_PIXEL, (c % 3 == 0) ? 8'h00 : 8'hFF);
    endtask

    // random rows under a tall height, with one long receiver hold
    task automatic test_random_rows;
        send_rows(3);
        hold_request = 1'b1;
        send_rows(FIRST_ROWS - 4);
        drain();
    endtask

    // lower the height part way through, then finish the image
    task automatic test_height_change;
        write_reg(mf3b_pkg::REG_IMAGE_HEIGHT, IMG_HEIGHT);
        send_rows(IMG_HEIGHT - FIRST_ROWS);
    endtask

    // flush words release the tail, then two with nothing pending
    task automatic test_flush;
        repeat (IMG_WIDTH + 3) send_word(KIND_FLUSH, mf3b_pkg::pixel_t'($urandom));
        drain();
    endtask

    // pixels after the image are ignored, whatever the size
    task automatic test_after_image;
        write_reg(mf3b_pkg::REG_IMAGE_HEIGHT, mf3b_pkg::DIM_MIN);
        write_reg(mf3b_pkg::REG_IMAGE_WIDTH, mf3b_pkg::DIM_MAX);
        repeat (4) send_word(mf3b_pkg::KIND_PIXEL, mf3b_pkg::pixel_t'($urandom));
        write_reg(mf3b_pkg::REG_IMAGE_WIDTH, mf3b_pkg::DIM_MIN);
        repeat (2) send_word(KIND_FLUSH, mf3b_pkg::pixel_t'($urandom));
        repeat (2) send_word(mf3b_pkg::KIND_PIXEL, mf3b_pkg::pixel_t'($urandom));
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_writes();
        test_early_flush();
        test_extreme_pixels();
        test_random_rows();
        test_height_change();
        test_flush();
        test_after_image();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver stall pattern with one long hold on request
    int stall_mode = 0, pattern_left = 0, hold_left = 0;
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (pattern_left == 0)
        begin
            pattern_left = $urandom_range(20, 200);
            stall_mode = $urandom_range(0, 2);
        end
        pattern_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        median_word_t m;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_medians.size() == 0)
            begin
                $display("%0t: result expected none got %0d at row %0d col %0d",
                         $time, median_value, out_row, out_col);
                mismatches++;
            end
            else
            begin
                m = expected_medians.pop_front();
                check_field("median_value", m.median, median_value);
                check_field("out_row", m.row, out_row);
                check_field("out_col", m.col, out_col);
                check_field("last_of_image", m.last, last_of_image);
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mf3b_pkg.sv
hdl/mf3b_ram.sv
hdl/median_filter_3x3_border_unit.sv
tb/tb_median_filter_3x3_border_unit.sv
